### design/ssca_pkg.sv
// ssca_pkg: shared types and constants for the segment closest-approach block.
// No dependencies; used by ssca_clamp, ssca_div, ssca_point and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ssca_pkg;

    // width of the tolerance register and of the squared distance
    localparam int TOL_W  = 16;
    localparam int DIST_W = 64;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    // how a clamped parameter is produced
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_ONE,
        MODE_DIV
    } mode_t;

    // control that travels with an item from the clamp logic into the divider
    typedef struct packed {
        logic  valid;
        mode_t s_mode;
        mode_t t_mode;
    } lane_ctl_t;

endpackage

`default_nettype wire

### design/ssca_quad.sv
// ssca_quad: dot products a..e, then denom, s and t numerators (6 stages).
// Depends on nothing but the coordinate layout given by the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssca_quad #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    input  wire  [12*COORD_WIDTH-1:0]        in_coords,
    output logic                             out_valid,
    output logic [12*COORD_WIDTH-1:0]        out_coords,
    output logic signed [2*COORD_WIDTH+2:0]  a,
    output logic signed [2*COORD_WIDTH+2:0]  b,
    output logic signed [2*COORD_WIDTH+2:0]  c,
    output logic signed [2*COORD_WIDTH+2:0]  d,
    output logic signed [2*COORD_WIDTH+2:0]  e,
    output logic signed [4*COORD_WIDTH+7:0]  denom,
    output logic signed [4*COORD_WIDTH+7:0]  sn,
    output logic signed [4*COORD_WIDTH+7:0]  tn
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2*CW+3;
    localparam int NW = 4*CW+8;
    localparam int VW = 12*CW;
    // half-width split of the wide cross products
    localparam int HB = (PW+1)/2;
    localparam int HW = PW-HB;
    localparam int XW = 2*HB+2;

    function automatic logic signed [CW-1:0] fld(input logic [VW-1:0] v, input int k);
        return $signed(v[k*CW +: CW]);
    endfunction

    // valid chain
    logic [5:0] v_reg;

    // stage 1: inputs and w0
    logic [VW-1:0]          c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic signed [CW:0]     w0_reg [3];
    logic signed [CW:0]     w0_next [3];
    // stage 2: products
    logic signed [PW-1:0]   paa_reg [3], pbb_reg [3], pcc_reg [3], pdd_reg [3], pee_reg [3];
    logic signed [PW-1:0]   paa_next [3], pbb_next [3], pcc_next [3], pdd_next [3], pee_next [3];
    // stage 3: sums
    logic signed [PW-1:0]   a3_reg, b3_reg, c3s_reg, d3_reg, e3_reg;
    // stage 4: partial products of ac, bb, be, cd, ae, bd
    logic signed [PW-1:0]   mx [6], my [6];
    logic signed [HW-1:0]   xh [6], yh [6];
    logic signed [HB:0]     xl [6], yl [6];
    logic signed [XW-1:0]   hh_next [6], hl_next [6], lh_next [6], ll_next [6];
    logic signed [XW-1:0]   hh_reg [6], hl_reg [6], lh_reg [6], ll_reg [6];
    logic signed [PW-1:0]   a4_reg, b4_reg, c4s_reg, d4_reg, e4_reg;
    // stage 5: cross products
    logic signed [PW-1:0]   a5_reg, b5_reg, c5s_reg, d5_reg, e5_reg;
    logic signed [NW-1:0]   prod_reg [6];
    // stage 6: differences
    logic signed [PW-1:0]   a6_reg, b6_reg, c6s_reg, d6_reg, e6_reg;
    logic signed [NW-1:0]   den_reg, sn_reg, tn_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            w0_next[k] = (CW+1)'(fld(in_coords, k)) - (CW+1)'(fld(in_coords, 6+k));
            paa_next[k] = PW'(fld(c1_reg, 3+k)) * PW'(fld(c1_reg, 3+k));
            pbb_next[k] = PW'(fld(c1_reg, 3+k)) * PW'(fld(c1_reg, 9+k));
            pcc_next[k] = PW'(fld(c1_reg, 9+k)) * PW'(fld(c1_reg, 9+k));
            pdd_next[k] = PW'(fld(c1_reg, 3+k)) * PW'(w0_reg[k]);
            pee_next[k] = PW'(fld(c1_reg, 9+k)) * PW'(w0_reg[k]);
        end
    end

    // cross products: signed high half, unsigned low half, four partials each
    always_comb
    begin
        mx[0] = a3_reg;  my[0] = c3s_reg;
        mx[1] = b3_reg;  my[1] = b3_reg;
        mx[2] = b3_reg;  my[2] = e3_reg;
        mx[3] = c3s_reg; my[3] = d3_reg;
        mx[4] = a3_reg;  my[4] = e3_reg;
        mx[5] = b3_reg;  my[5] = d3_reg;
        for (int j = 0; j < 6; j++)
        begin
            xh[j] = mx[j][PW-1:HB];
            yh[j] = my[j][PW-1:HB];
            xl[j] = {1'b0, mx[j][HB-1:0]};
            yl[j] = {1'b0, my[j][HB-1:0]};
            hh_next[j] = XW'(xh[j]) * XW'(yh[j]);
            hl_next[j] = XW'(xh[j]) * XW'(yl[j]);
            lh_next[j] = XW'(xl[j]) * XW'(yh[j]);
            ll_next[j] = XW'(xl[j]) * XW'(yl[j]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        c1_reg <= in_coords;
        w0_reg <= w0_next;
        c2_reg <= c1_reg;
        paa_reg <= paa_next;
        pbb_reg <= pbb_next;
        pcc_reg <= pcc_next;
        pdd_reg <= pdd_next;
        pee_reg <= pee_next;
        c3_reg  <= c2_reg;
        a3_reg  <= paa_reg[0] + paa_reg[1] + paa_reg[2];
        b3_reg  <= pbb_reg[0] + pbb_reg[1] + pbb_reg[2];
        c3s_reg <= pcc_reg[0] + pcc_reg[1] + pcc_reg[2];
        d3_reg  <= pdd_reg[0] + pdd_reg[1] + pdd_reg[2];
        e3_reg  <= pee_reg[0] + pee_reg[1] + pee_reg[2];
        c4_reg  <= c3_reg;
        a4_reg  <= a3_reg;
        b4_reg  <= b3_reg;
        c4s_reg <= c3s_reg;
        d4_reg  <= d3_reg;
        e4_reg  <= e3_reg;
        hh_reg  <= hh_next;
        hl_reg  <= hl_next;
        lh_reg  <= lh_next;
        ll_reg  <= ll_next;
        c5_reg  <= c4_reg;
        a5_reg  <= a4_reg;
        b5_reg  <= b4_reg;
        c5s_reg <= c4s_reg;
        d5_reg  <= d4_reg;
        e5_reg  <= e4_reg;
        for (int j = 0; j < 6; j++)
        begin
            prod_reg[j] <= (NW'(hh_reg[j]) <<< (2*HB))
                         + ((NW'(hl_reg[j]) + NW'(lh_reg[j])) <<< HB)
                         + NW'(ll_reg[j]);
        end
        c6_reg  <= c5_reg;
        a6_reg  <= a5_reg;
        b6_reg  <= b5_reg;
        c6s_reg <= c5s_reg;
        d6_reg  <= d5_reg;
        e6_reg  <= e5_reg;
        den_reg <= prod_reg[0] - prod_reg[1];
        sn_reg  <= prod_reg[2] - prod_reg[3];
        tn_reg  <= prod_reg[4] - prod_reg[5];
    end

    assign out_valid  = v_reg[5];
    assign out_coords = c6_reg;
    assign a     = a6_reg;
    assign b     = b6_reg;
    assign c     = c6s_reg;
    assign d     = d6_reg;
    assign e     = e6_reg;
    assign denom = den_reg;
    assign sn    = sn_reg;
    assign tn    = tn_reg;

endmodule

`default_nettype wire

### design/ssca_clamp.sv
// ssca_clamp: parallel test and re-clamping branches, picks divider operands (4 stages).
// Depends on ssca_pkg (mode_t, lane_ctl_t, TOL_W).
`timescale 1ns / 1ps
`default_nettype none

module ssca_clamp #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    input  wire  [ssca_pkg::TOL_W-1:0]       tol,
    input  wire  [12*COORD_WIDTH-1:0]        in_coords,
    input  wire  signed [2*COORD_WIDTH+2:0]  a,
    input  wire  signed [2*COORD_WIDTH+2:0]  b,
    input  wire  signed [2*COORD_WIDTH+2:0]  c,
    input  wire  signed [2*COORD_WIDTH+2:0]  d,
    input  wire  signed [2*COORD_WIDTH+2:0]  e,
    input  wire  signed [4*COORD_WIDTH+7:0]  denom,
    input  wire  signed [4*COORD_WIDTH+7:0]  sn,
    input  wire  signed [4*COORD_WIDTH+7:0]  tn,
    output ssca_pkg::lane_ctl_t              ctl,
    output logic [12*COORD_WIDTH-1:0]        out_coords,
    output logic signed [4*COORD_WIDTH+7:0]  s_num,
    output logic signed [4*COORD_WIDTH+7:0]  s_den,
    output logic signed [4*COORD_WIDTH+7:0]  t_num,
    output logic signed [4*COORD_WIDTH+7:0]  t_den
);

    localparam int CW = COORD_WIDTH;
    localparam int NW = 4*CW+8;
    localparam int VW = 12*CW;

    logic [3:0]            v_reg;
    logic [VW-1:0]         co1_reg, co2_reg, co3_reg, co4_reg;
    logic signed [NW-1:0]  tol_ext;
    logic signed [NW-1:0]  den_abs;

    // stage 1 registers
    logic                  par_reg, snneg_reg, sngt_reg;
    logic signed [NW-1:0]  a1_reg, b1_reg, c1_reg, d1_reg, e1_reg, den1_reg, sn1_reg, tn1_reg;
    // stage 2 registers
    logic signed [NW-1:0]  a2_reg, sn2_reg, sd2_reg, tn2_reg, td2_reg, nd2_reg, nb2_reg;
    logic signed [NW-1:0]  sn2_next, sd2_next, tn2_next, td2_next;
    // stage 3 registers
    logic signed [NW-1:0]  a3_reg, sn3_reg, sd3_reg, tn3_reg, td3_reg, nd3_reg, nb3_reg;
    logic                  tnneg_reg, tngt_reg, ndneg_reg, ndgt_reg, nbneg_reg, nbgt_reg;
    // stage 4 registers
    ssca_pkg::mode_t       sm_reg, tm_reg, sm_next, tm_next;
    logic signed [NW-1:0]  snum_reg, sden_reg, tnum_reg, tden_reg;
    logic signed [NW-1:0]  snum_next, sden_next, tnum_next, tden_next;

    assign tol_ext = {{(NW-ssca_pkg::TOL_W){1'b0}}, tol};
    assign den_abs = denom[NW-1] ? -denom : denom;

    // stage 2 select: parallel case and s clamping
    always_comb
    begin
        sd2_next = den1_reg;
        td2_next = den1_reg;
        sn2_next = sn1_reg;
        tn2_next = tn1_reg;
        if (par_reg)
        begin
            sd2_next = c1_reg;
            td2_next = c1_reg;
            sn2_next = '0;
            tn2_next = e1_reg;
        end
        else if (snneg_reg)
        begin
            sn2_next = '0;
            tn2_next = e1_reg;
            td2_next = c1_reg;
        end
        else if (sngt_reg)
        begin
            sn2_next = den1_reg;
            tn2_next = e1_reg + b1_reg;
            td2_next = c1_reg;
        end
    end

    // stage 4 select: t clamping and the s re-clamp
    always_comb
    begin
        tm_next   = ssca_pkg::MODE_DIV;
        sm_next   = ssca_pkg::MODE_DIV;
        tnum_next = tn3_reg;
        tden_next = td3_reg;
        snum_next = sn3_reg;
        sden_next = sd3_reg;
        if (tnneg_reg)
        begin
            tm_next   = ssca_pkg::MODE_ZERO;
            snum_next = nd3_reg;
            sden_next = a3_reg;
            if (ndneg_reg)
                sm_next = ssca_pkg::MODE_ZERO;
            else if (ndgt_reg)
                sm_next = ssca_pkg::MODE_ONE;
        end
        else if (tngt_reg)
        begin
            tm_next   = ssca_pkg::MODE_ONE;
            snum_next = nb3_reg;
            sden_next = a3_reg;
            if (nbneg_reg)
                sm_next = ssca_pkg::MODE_ZERO;
            else if (nbgt_reg)
                sm_next = ssca_pkg::MODE_ONE;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        co1_reg   <= in_coords;
        par_reg   <= den_abs <= tol_ext;
        snneg_reg <= sn < 0;
        sngt_reg  <= sn > denom;
        a1_reg    <= NW'(a);
        b1_reg    <= NW'(b);
        c1_reg    <= NW'(c);
        d1_reg    <= NW'(d);
        e1_reg    <= NW'(e);
        den1_reg  <= denom;
        sn1_reg   <= sn;
        tn1_reg   <= tn;

        co2_reg <= co1_reg;
        a2_reg  <= a1_reg;
        sn2_reg <= sn2_next;
        sd2_reg <= sd2_next;
        tn2_reg <= tn2_next;
        td2_reg <= td2_next;
        nd2_reg <= -d1_reg;
        nb2_reg <= b1_reg - d1_reg;

        co3_reg   <= co2_reg;
        a3_reg    <= a2_reg;
        sn3_reg   <= sn2_reg;
        sd3_reg   <= sd2_reg;
        tn3_reg   <= tn2_reg;
        td3_reg   <= td2_reg;
        nd3_reg   <= nd2_reg;
        nb3_reg   <= nb2_reg;
        tnneg_reg <= tn2_reg < 0;
        tngt_reg  <= tn2_reg > td2_reg;
        ndneg_reg <= nd2_reg < 0;
        ndgt_reg  <= nd2_reg > a2_reg;
        nbneg_reg <= nb2_reg < 0;
        nbgt_reg  <= nb2_reg > a2_reg;

        co4_reg  <= co3_reg;
        sm_reg   <= sm_next;
        tm_reg   <= tm_next;
        snum_reg <= snum_next;
        sden_reg <= sden_next;
        tnum_reg <= tnum_next;
        tden_reg <= tden_next;
    end

    assign ctl.valid  = v_reg[3];
    assign ctl.s_mode = sm_reg;
    assign ctl.t_mode = tm_reg;
    assign out_coords = co4_reg;
    assign s_num = snum_reg;
    assign s_den = sden_reg;
    assign t_num = tnum_reg;
    assign t_den = tden_reg;

endmodule

`default_nettype wire

### design/ssca_div.sv
// ssca_div: two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on ssca_pkg (mode_t, lane_ctl_t); prep stage, quotient stages, then result register.
`timescale 1ns / 1ps
`default_nettype none

module ssca_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  ssca_pkg::lane_ctl_t              ctl,
    input  wire  [12*COORD_WIDTH-1:0]        in_coords,
    input  wire  signed [4*COORD_WIDTH+7:0]  s_num,
    input  wire  signed [4*COORD_WIDTH+7:0]  s_den,
    input  wire  signed [4*COORD_WIDTH+7:0]  t_num,
    input  wire  signed [4*COORD_WIDTH+7:0]  t_den,
    output logic                             out_valid,
    output logic [12*COORD_WIDTH-1:0]        out_coords,
    output logic [FRAC_BITS:0]               s_param,
    output logic [FRAC_BITS:0]               t_param
);

    localparam int NW = 4*COORD_WIDTH+8;
    localparam int VW = 12*COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    logic                  v_reg   [FB+1];
    logic [VW-1:0]         co_reg  [FB+1];
    ssca_pkg::mode_t       mode_reg [FB+1][2];
    logic [NW-1:0]         rem_reg [FB+1][2];
    logic [NW-1:0]         den_reg [FB+1][2];
    logic [FB-1:0]         q_reg   [FB+1][2];

    logic signed [NW-1:0]  num_in [2];
    logic signed [NW-1:0]  den_in [2];
    ssca_pkg::mode_t       mode_in [2];
    ssca_pkg::mode_t       mode_pre [2];

    logic                  vo_reg;
    logic [VW-1:0]         coo_reg;
    logic [FB:0]           par_reg [2];
    logic [FB:0]           par_next [2];

    assign num_in[0]  = s_num;
    assign num_in[1]  = t_num;
    assign den_in[0]  = s_den;
    assign den_in[1]  = t_den;
    assign mode_in[0] = ctl.s_mode;
    assign mode_in[1] = ctl.t_mode;

    // operand screening: bad divisor, negative numerator, quotient at least one
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mode_pre[l] = mode_in[l];
            if (mode_in[l] == ssca_pkg::MODE_DIV)
            begin
                if (den_in[l] <= 0 || num_in[l] < 0)
                    mode_pre[l] = ssca_pkg::MODE_ZERO;
                else if (num_in[l] >= den_in[l])
                    mode_pre[l] = ssca_pkg::MODE_ONE;
            end
        end
    end

    // prep stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        co_reg[0] <= in_coords;
        for (int l = 0; l < 2; l++)
        begin
            mode_reg[0][l] <= mode_pre[l];
            rem_reg[0][l]  <= num_in[l];
            den_reg[0][l]  <= den_in[l];
            q_reg[0][l]    <= '0;
        end
    end

    // quotient stages, most significant bit first
    for (genvar i = 1; i <= FB; i++)
    begin : g_step
        logic [NW:0]   trial [2];
        logic [NW-1:0] rem_next [2];
        logic [FB-1:0] q_next [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l]    = {rem_reg[i-1][l], 1'b0};
                rem_next[l] = trial[l][NW-1:0];
                q_next[l]   = q_reg[i-1][l];
                if (trial[l] >= {1'b0, den_reg[i-1][l]})
                begin
                    rem_next[l]     = NW'(trial[l] - {1'b0, den_reg[i-1][l]});
                    q_next[l][FB-i] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            co_reg[i]   <= co_reg[i-1];
            mode_reg[i] <= mode_reg[i-1];
            den_reg[i]  <= den_reg[i-1];
            rem_reg[i]  <= rem_next;
            q_reg[i]    <= q_next;
        end
    end

    // result select
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            unique case (mode_reg[FB][l])
                ssca_pkg::MODE_ONE: par_next[l] = ONE;
                ssca_pkg::MODE_DIV: par_next[l] = {1'b0, q_reg[FB][l]};
                default:            par_next[l] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= v_reg[FB];
        end
    end

    always_ff @(posedge clk)
    begin
        coo_reg <= co_reg[FB];
        par_reg <= par_next;
    end

    assign out_valid  = vo_reg;
    assign out_coords = coo_reg;
    assign s_param    = par_reg[0];
    assign t_param    = par_reg[1];

endmodule

`default_nettype wire

### design/ssca_point.sv
// ssca_point: closest points and squared distance from the clamped s and t (5 stages).
// Depends on ssca_pkg (DIST_W).
`timescale 1ns / 1ps
`default_nettype none

module ssca_point #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    input  wire  [12*COORD_WIDTH-1:0]          in_coords,
    input  wire  [FRAC_BITS:0]                 s_in,
    input  wire  [FRAC_BITS:0]                 t_in,
    output logic                               out_valid,
    output logic [ssca_pkg::DIST_W-1:0]        dist_sq,
    output logic [FRAC_BITS:0]                 s_out,
    output logic [FRAC_BITS:0]                 t_out,
    output logic signed [COORD_WIDTH-1:0]      near0 [3],
    output logic signed [COORD_WIDTH-1:0]      near1 [3]
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int VW  = 12*CW;
    localparam int DW  = ssca_pkg::DIST_W;
    localparam int MW  = CW+FB+2;
    localparam int WCW = CW+FB+4;
    localparam int SW  = 2*WCW;
    localparam int SQW = 2*WCW+2+DW;
    // half-width split of the squares
    localparam int QB  = WCW/2;
    localparam int QH  = WCW-QB;
    localparam int QX  = 2*QB+2;
    localparam logic signed [CW+2:0] PMAX = (CW+3)'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [CW+2:0] PMIN = -PMAX - (CW+3)'(1);

    function automatic logic signed [CW-1:0] fld(input logic [VW-1:0] v, input int k);
        return $signed(v[k*CW +: CW]);
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [CW+2:0] x);
        if (x > PMAX)
            return PMAX[CW-1:0];
        else if (x < PMIN)
            return PMIN[CW-1:0];
        return x[CW-1:0];
    endfunction

    logic [4:0]             v_reg;
    logic [FB:0]            s1_reg, t1_reg, s2_reg, t2_reg, s3_reg, t3_reg, s4_reg, t4_reg;
    logic [FB:0]            s5_reg, t5_reg;
    // stage 1
    logic signed [MW-1:0]   sd0_reg [3], td1_reg [3];
    logic signed [CW:0]     w0_reg [3];
    logic signed [CW-1:0]   o0_reg [3], o1_reg [3];
    // stage 2
    logic signed [CW-1:0]   n0_reg [3], n1_reg [3], n0_3_reg [3], n1_3_reg [3];
    logic signed [CW-1:0]   n0_4_reg [3], n1_4_reg [3], n0_5_reg [3], n1_5_reg [3];
    logic signed [WCW-1:0]  wc_reg [3];
    // stage 3: partial products of the squares
    logic signed [QH-1:0]   wh [3];
    logic signed [QB:0]     wl [3];
    logic signed [QX-1:0]   hh_reg [3], hl_reg [3], ll_reg [3];
    // stage 4
    logic [SW-1:0]          sq_reg [3];
    // stage 5
    logic [DW-1:0]          dist_reg;
    logic [SQW-1:0]         sum;
    logic [SQW-1:0]         shifted;

    // split each difference component into signed high and unsigned low halves
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            wh[k] = wc_reg[k][WCW-1:QB];
            wl[k] = {1'b0, wc_reg[k][QB-1:0]};
        end
    end

    // distance: sum of squares, drop 2*FRAC_BITS, saturate
    assign sum     = SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
    assign shifted = sum >> (2*FB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s_in;
        t1_reg <= t_in;
        s2_reg <= s1_reg;
        t2_reg <= t1_reg;
        s3_reg <= s2_reg;
        t3_reg <= t2_reg;
        s4_reg <= s3_reg;
        t4_reg <= t3_reg;
        s5_reg <= s4_reg;
        t5_reg <= t4_reg;
        for (int k = 0; k < 3; k++)
        begin
            // stage 1: param times direction
            sd0_reg[k] <= MW'($signed({1'b0, s_in})) * MW'(fld(in_coords, 3+k));
            td1_reg[k] <= MW'($signed({1'b0, t_in})) * MW'(fld(in_coords, 9+k));
            w0_reg[k]  <= (CW+1)'(fld(in_coords, k)) - (CW+1)'(fld(in_coords, 6+k));
            o0_reg[k]  <= fld(in_coords, k);
            o1_reg[k]  <= fld(in_coords, 6+k);
            // stage 2: points and exact difference vector
            n0_reg[k] <= sat((CW+3)'(o0_reg[k]) + (CW+3)'(sd0_reg[k] >>> FB));
            n1_reg[k] <= sat((CW+3)'(o1_reg[k]) + (CW+3)'(td1_reg[k] >>> FB));
            wc_reg[k] <= (WCW'(w0_reg[k]) <<< FB) + WCW'(sd0_reg[k]) - WCW'(td1_reg[k]);
            // stage 3: partial squares
            hh_reg[k]   <= QX'(wh[k]) * QX'(wh[k]);
            hl_reg[k]   <= QX'(wh[k]) * QX'(wl[k]);
            ll_reg[k]   <= QX'(wl[k]) * QX'(wl[k]);
            n0_3_reg[k] <= n0_reg[k];
            n1_3_reg[k] <= n1_reg[k];
            // stage 4: squares, cross term counted twice
            sq_reg[k]   <= (SW'(hh_reg[k]) <<< (2*QB)) + (SW'(hl_reg[k]) <<< (QB+1))
                         + SW'(ll_reg[k]);
            n0_4_reg[k] <= n0_3_reg[k];
            n1_4_reg[k] <= n1_3_reg[k];
            // stage 5
            n0_5_reg[k] <= n0_4_reg[k];
            n1_5_reg[k] <= n1_4_reg[k];
        end
        dist_reg <= (|shifted[SQW-1:DW]) ? '1 : shifted[DW-1:0];
    end

    assign out_valid = v_reg[4];
    assign dist_sq   = dist_reg;
    assign s_out     = s5_reg;
    assign t_out     = t5_reg;
    assign near0     = n0_5_reg;
    assign near1     = n1_5_reg;

endmodule

`default_nettype wire

### design/segment_segment_closest_approach.sv
// segment_segment_closest_approach: top level, closest approach of two 3D segments.
// Depends on ssca_pkg, ssca_quad, ssca_clamp, ssca_div, ssca_point.
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------------
//  command   start / busy         first_/second_ origin_xyz, dir_xyz
//  result    done (strobe)        distance_squared, first/second_param, near_*
//  config    cfg_valid/cfg_ready  cfg_data (parallel_tolerance)
//
// One segment pair is taken every cycle; busy is never raised.
// done pulses once the pair has passed ssca_quad, ssca_clamp, ssca_div and ssca_point
// in that order; the divider gives one quotient bit per stage, FRAC_BITS stages.
// Results cannot be held off; each is shown for exactly one cycle.
// Reset clears all valid bits and sets parallel_tolerance to 1.
`timescale 1ns / 1ps
`default_nettype none

module segment_segment_closest_approach #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  signed [COORD_WIDTH-1:0]       first_origin_x,
    input  wire  signed [COORD_WIDTH-1:0]       first_origin_y,
    input  wire  signed [COORD_WIDTH-1:0]       first_origin_z,
    input  wire  signed [COORD_WIDTH-1:0]       first_dir_x,
    input  wire  signed [COORD_WIDTH-1:0]       first_dir_y,
    input  wire  signed [COORD_WIDTH-1:0]       first_dir_z,
    input  wire  signed [COORD_WIDTH-1:0]       second_origin_x,
    input  wire  signed [COORD_WIDTH-1:0]       second_origin_y,
    input  wire  signed [COORD_WIDTH-1:0]       second_origin_z,
    input  wire  signed [COORD_WIDTH-1:0]       second_dir_x,
    input  wire  signed [COORD_WIDTH-1:0]       second_dir_y,
    input  wire  signed [COORD_WIDTH-1:0]       second_dir_z,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ssca_pkg::TOL_W-1:0]          cfg_data,
    output logic                                done,
    output logic [ssca_pkg::DIST_W-1:0]         distance_squared,
    output logic [FRAC_BITS:0]                  first_param,
    output logic [FRAC_BITS:0]                  second_param,
    output logic signed [COORD_WIDTH-1:0]       near_first_x,
    output logic signed [COORD_WIDTH-1:0]       near_first_y,
    output logic signed [COORD_WIDTH-1:0]       near_first_z,
    output logic signed [COORD_WIDTH-1:0]       near_second_x,
    output logic signed [COORD_WIDTH-1:0]       near_second_y,
    output logic signed [COORD_WIDTH-1:0]       near_second_z
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2*CW+3;
    localparam int NW  = 4*CW+8;
    localparam int VW  = 12*CW;
    localparam int LAT = FRAC_BITS+17;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [ssca_pkg::TOL_W-1:0] tol_reg;
    logic [VW-1:0]              coords, q_co, c_co, d_co;
    logic                       q_valid, d_valid;
    logic signed [PW-1:0]       qa, qb, qc, qd, qe;
    logic signed [NW-1:0]       qden, qsn, qtn;
    ssca_pkg::lane_ctl_t        c_ctl;
    logic signed [NW-1:0]       s_num, s_den, t_num, t_den;
    logic [FRAC_BITS:0]         d_s, d_t;
    logic signed [CW-1:0]       near0 [3], near1 [3];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // coordinates flattened in command field order
    assign coords = {second_dir_z, second_dir_y, second_dir_x,
                     second_origin_z, second_origin_y, second_origin_x,
                     first_dir_z, first_dir_y, first_dir_x,
                     first_origin_z, first_origin_y, first_origin_x};

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= ssca_pkg::TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    ssca_quad #(.COORD_WIDTH(CW)) u_quad (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .in_coords  (coords),
        .out_valid  (q_valid),
        .out_coords (q_co),
        .a          (qa),
        .b          (qb),
        .c          (qc),
        .d          (qd),
        .e          (qe),
        .denom      (qden),
        .sn         (qsn),
        .tn         (qtn)
    );

    ssca_clamp #(.COORD_WIDTH(CW)) u_clamp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .tol        (tol_reg),
        .in_coords  (q_co),
        .a          (qa),
        .b          (qb),
        .c          (qc),
        .d          (qd),
        .e          (qe),
        .denom      (qden),
        .sn         (qsn),
        .tn         (qtn),
        .ctl        (c_ctl),
        .out_coords (c_co),
        .s_num      (s_num),
        .s_den      (s_den),
        .t_num      (t_num),
        .t_den      (t_den)
    );

    ssca_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (c_ctl),
        .in_coords  (c_co),
        .s_num      (s_num),
        .s_den      (s_den),
        .t_num      (t_num),
        .t_den      (t_den),
        .out_valid  (d_valid),
        .out_coords (d_co),
        .s_param    (d_s),
        .t_param    (d_t)
    );

    ssca_point #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_point (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_coords  (d_co),
        .s_in       (d_s),
        .t_in       (d_t),
        .out_valid  (done),
        .dist_sq    (distance_squared),
        .s_out      (first_param),
        .t_out      (second_param),
        .near0      (near0),
        .near1      (near1)
    );

    assign near_first_x  = near0[0];
    assign near_first_y  = near0[1];
    assign near_first_z  = near0[2];
    assign near_second_x = near1[0];
    assign near_second_y = near1[1];
    assign near_second_z = near1[2];

    // every command produces its result after the fixed pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("result strobe missing after command");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without command");

    a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> first_param <= ONE)
        else $error("first_param above one");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> second_param <= ONE)
        else $error("second_param above one");

endmodule

`default_nettype wire

### dv/tb_segment_segment_closest_approach.sv
// tb_segment_segment_closest_approach: self-checking bench for the segment closest-approach block.
// Depends on ssca_pkg and segment_segment_closest_approach; compares each result with a
// bit-exact wide-integer prediction held in the bench.
`timescale 1ns / 1ps

module tb_segment_segment_closest_approach;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [FB:0] PARAM_ONE = 17'h10000;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;
    // field order: first origin xyz, first dir xyz, second origin xyz, second dir xyz
    typedef coord_t seg_pair_t [12];

    typedef struct {
        logic [ssca_pkg::DIST_W-1:0] dist_sq;
        logic [FB:0]       s;
        logic [FB:0]       t;
        coord_t            p0 [3];
        coord_t            p1 [3];
    } approach_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    coord_t coords [12];
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ssca_pkg::TOL_W-1:0] cfg_data = '0;
    logic done;
    logic [ssca_pkg::DIST_W-1:0] distance_squared;
    logic [FB:0] first_param, second_param;
    coord_t near_first_x, near_first_y, near_first_z;
    coord_t near_second_x, near_second_y, near_second_z;

    approach_t expected_q [$];
    logic [ssca_pkg::TOL_W-1:0] tolerance = ssca_pkg::TOL_RESET;
    bit idle_on = 1'b1;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int tol_writes = 0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    initial begin
        for (int i = 0; i < 12; i++)
        begin
            coords[i] = '0;
        end
    end

    segment_segment_closest_approach dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_origin_x(coords[0]), .first_origin_y(coords[1]), .first_origin_z(coords[2]),
        .first_dir_x(coords[3]), .first_dir_y(coords[4]), .first_dir_z(coords[5]),
        .second_origin_x(coords[6]), .second_origin_y(coords[7]),
        .second_origin_z(coords[8]),
        .second_dir_x(coords[9]), .second_dir_y(coords[10]), .second_dir_z(coords[11]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .distance_squared(distance_squared),
        .first_param(first_param), .second_param(second_param),
        .near_first_x(near_first_x), .near_first_y(near_first_y),
        .near_first_z(near_first_z),
        .near_second_x(near_second_x), .near_second_y(near_second_y),
        .near_second_z(near_second_z)
    );

    // floor(num * 2^FB / den), zero for non-positive den or negative num, capped at one
    function automatic logic [FB:0] clamped_quotient(wide_t num, wide_t den);
        wide_t q;
        if (den <= 0 || num < 0)
            return '0;
        q = (num <<< FB) / den;
        if (q > $signed({239'd0, PARAM_ONE}))
            return PARAM_ONE;
        return q[FB:0];
    endfunction

    function automatic coord_t saturate_coord(wide_t v);
        if (v > $signed({224'd0, 32'h7fffffff}))
            return 32'h7fffffff;
        if (v < -$signed({224'd0, 32'h80000000}))
            return 32'h80000000;
        return v[CW-1:0];
    endfunction

    // closest approach of the two segments, exact integer arithmetic
    function automatic approach_t closest_approach(seg_pair_t p,
                                                   logic [ssca_pkg::TOL_W-1:0] tol);
        wide_t o0 [3], d0 [3], o1 [3], d1 [3], w0 [3], wc [3];
        wide_t a, b, c, dd, e, den, sn, sd, tn, td, mag, fs, ft, sd0, td1, sq;
        logic [FB:0] s, t;
        approach_t r;
        a = 0; b = 0; c = 0; dd = 0; e = 0;
        for (int k = 0; k < 3; k++)
        begin
            o0[k] = p[k]; d0[k] = p[3+k]; o1[k] = p[6+k]; d1[k] = p[9+k];
            w0[k] = o0[k] - o1[k];
            a += d0[k] * d0[k];
            b += d0[k] * d1[k];
            c += d1[k] * d1[k];
            dd += d0[k] * w0[k];
            e += d1[k] * w0[k];
        end
        den = a * c - b * b;
        mag = den < 0 ? -den : den;
        if (mag <= $signed({240'd0, tol}))
        begin
            // near-parallel: pin s to the first segment start
            sd = c; td = c; sn = 0; tn = e;
        end
        else
        begin
            sd = den; td = den;
            sn = b * e - c * dd;
            tn = a * e - b * dd;
            if (sn < 0)
            begin
                sn = 0; tn = e; td = c;
            end
            else if (sn > sd)
            begin
                sn = sd; tn = e + b; td = c;
            end
        end
        // re-clamp t, then s against it
        if (tn < 0)
        begin
            t = '0;
            if (-dd < 0) s = '0;
            else if (-dd > a) s = PARAM_ONE;
            else s = clamped_quotient(-dd, a);
        end
        else if (tn > td)
        begin
            t = PARAM_ONE;
            if (b - dd < 0) s = '0;
            else if (b - dd > a) s = PARAM_ONE;
            else s = clamped_quotient(b - dd, a);
        end
        else
        begin
            t = clamped_quotient(tn, td);
            s = clamped_quotient(sn, sd);
        end
        fs = $signed({239'd0, s});
        ft = $signed({239'd0, t});
        sq = 0;
        for (int k = 0; k < 3; k++)
        begin
            sd0 = fs * d0[k];
            td1 = ft * d1[k];
            r.p0[k] = saturate_coord(o0[k] + (sd0 >>> FB));
            r.p1[k] = saturate_coord(o1[k] + (td1 >>> FB));
            wc[k] = (w0[k] <<< FB) + sd0 - td1;
            sq += wc[k] * wc[k];
        end
        sq = sq >>> (2 * FB);
        r.dist_sq = (sq[255:64] != 0) ? '1 : sq[63:0];
        r.s = s;
        r.t = t;
        return r;
    endfunction

    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker: one result per done strobe
    always @(posedge clk)
    begin
        approach_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual dist %h",
                         $time, distance_squared);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                report_field("distance_squared", want.dist_sq, distance_squared);
                report_field("first_param", 64'(want.s), 64'(first_param));
                report_field("second_param", 64'(want.t), 64'(second_param));
                report_field("near_first_x", 64'(want.p0[0]), 64'(near_first_x));
                report_field("near_first_y", 64'(want.p0[1]), 64'(near_first_y));
                report_field("near_first_z", 64'(want.p0[2]), 64'(near_first_z));
                report_field("near_second_x", 64'(want.p1[0]), 64'(near_second_x));
                report_field("near_second_y", 64'(want.p1[1]), 64'(near_second_y));
                report_field("near_second_z", 64'(want.p1[2]), 64'(near_second_z));
                results_checked++;
            end
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // one command transfer, with an optional idle burst first
    task automatic send_pair(seg_pair_t p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        for (int i = 0; i < 12; i++)
        begin
            coords[i] <= p[i];
        end
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(closest_approach(p, tolerance));
        items_sent++;
    endtask

    // tolerance write once the pipeline has drained
    task automatic write_tolerance(logic [ssca_pkg::TOL_W-1:0] value);
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tolerance = value;
        tol_writes++;
    endtask

    function automatic coord_t random_coord(int kind);
        case (kind)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: return coord_t'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            3: return coord_t'($urandom_range(0, 16)) - 32'sd8;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int kind, shape, m;
        kind = $urandom_range(0, 9);
        kind = kind < 2 ? 0 : kind < 6 ? 1 : kind < 8 ? 2 : kind < 9 ? 3 : 4;
        shape = $urandom_range(0, 15);
        for (int i = 0; i < 12; i++)
        begin
            p[i] = random_coord(kind);
        end
        // parallel, antiparallel or doubled second direction
        if (shape < 3)
        begin
            m = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
            begin
                p[9+k] = m == 0 ? p[3+k] : m == 1 ? -p[3+k] : p[3+k] * 2;
            end
        end
        // degenerate segments
        else if (shape == 3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[3+k] = '0;
            end
        end
        else if (shape == 4)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[9+k] = '0;
            end
        end
        return p;
    endfunction

    function automatic seg_pair_t make_pair(int ox, int oy, int oz, int dx, int dy, int dz,
                                            int qx, int qy, int qz, int ex, int ey, int ez);
        seg_pair_t p;
        p[0] = ox; p[1] = oy; p[2] = oz; p[3] = dx; p[4] = dy; p[5] = dz;
        p[6] = qx; p[7] = qy; p[8] = qz; p[9] = ex; p[10] = ey; p[11] = ez;
        return p;
    endfunction

    // extremes, clamp branches, parallel and degenerate cases
    task automatic test_directed();
        localparam int U = 65536;
        seg_pair_t p;
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, U, 0, 0, 0, U, 0, 0, 0, U));
        send_pair(make_pair(-U, 0, 0, 2*U, 0, 0, 0, -U, U, 0, 2*U, 0));
        send_pair(make_pair(0, 0, 0, U, 0, 0, 0, U, 0, U, 0, 0));
        send_pair(make_pair(0, 0, 0, U, 0, 0, 3*U, U, 0, -U, 0, 0));
        send_pair(make_pair(0, 0, 0, U, 0, 0, -5*U, 2*U, 0, 0, U, 0));
        send_pair(make_pair(0, 0, 0, U, 0, 0, 5*U, -3*U, 0, 0, U, 0));
        send_pair(make_pair(0, 0, 0, U, U, 0, -4*U, 3*U, 2*U, 0, 0, U));
        send_pair(make_pair(0, 0, 0, U, 0, 0, 9*U, 9*U, 9*U, U, U, U));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, U, U, U, U, 0, 0));
        send_pair(make_pair(U, U, U, U, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(U, U, U, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        for (int i = 0; i < 12; i++)
        begin
            p[i] = 32'h7fffffff;
        end
        send_pair(p);
        for (int i = 0; i < 12; i++)
        begin
            p[i] = 32'h80000000;
        end
        send_pair(p);
        for (int i = 0; i < 12; i++)
        begin
            p[i] = (i % 6) < 3 ? 32'h7fffffff : 32'h80000000;
        end
        send_pair(p);
        for (int i = 0; i < 12; i++)
        begin
            p[i] = (i < 6) ? 32'h7fffffff : 32'h80000000;
        end
        send_pair(p);
        for (int i = 0; i < 12; i++)
        begin
            p[i] = -32'sd1;
        end
        send_pair(p);
    endtask

    // tolerance settings around near-parallel pairs and random pairs
    task automatic test_tolerance();
        logic [ssca_pkg::TOL_W-1:0] settings [4] = '{16'd0, 16'hffff, 16'd300, 16'h8000};
        seg_pair_t p;
        foreach (settings[n])
        begin
            write_tolerance(settings[n]);
            send_pair(make_pair(0, 0, 0, 2, 0, 0, 0, 0, 0, 2, 1, 0));
            send_pair(make_pair(0, 0, 0, 16, 0, 0, 0, 5, 0, 16, 1, 0));
            send_pair(make_pair(0, 0, 0, 256, 0, 0, 100, 3, 0, 256, 1, 0));
            send_pair(make_pair(0, 0, 0, 1, 1, 0, 0, 0, 0, 1, 0, 0));
            for (int i = 0; i < 4; i++)
            begin
                p = random_pair();
                send_pair(p);
            end
        end
    endtask

    task automatic test_random(int count, logic [ssca_pkg::TOL_W-1:0] tol, bit with_idle);
        write_tolerance(tol);
        idle_on = with_idle;
        for (int i = 0; i < count; i++)
        begin
            send_pair(random_pair());
        end
    endtask

    initial
    begin
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tolerance();
        test_random(400, 16'd1, 1'b1);
        test_random(300, 16'd0, 1'b1);
        test_random(300, 16'hffff, 1'b1);
        test_random(300, 16'($urandom), 1'b1);
        test_random(200, 16'd1, 1'b0);
        start <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 10 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            errors++;
        end
        $display("Sent %0d segment pairs, checked %0d results, %0d tolerance writes.",
                 items_sent, results_checked, tol_writes);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
